// File: hdl/tcfp_pkg.sv
// Shared types and constants for the touch contact frame parser.
// No dependencies; imported by touch_contact_frame_parser.
package tcfp_pkg;

  localparam int POS_W = 17;   // byte position reaches 5 + 65535
  localparam int LEN_W = 16;
  localparam int REC_BYTES = 15;   // record bytes held before the last one arrives

  localparam logic [POS_W-1:0] POS_ACK    = 17'd0;
  localparam logic [POS_W-1:0] POS_LEN_LO = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI = 17'd4;
  localparam logic [POS_W-1:0] POS_FLAG   = 17'd5;
  localparam logic [POS_W-1:0] POS_COUNT  = 17'd12;
  localparam logic [POS_W-1:0] REC_START  = 17'd13;
  localparam logic [POS_W-1:0] END_OFFSET = 17'd5;
  localparam logic [LEN_W-1:0] HDR_OVERHEAD = 16'd8;
  localparam logic [3:0] REC_START_LSB = 4'd13;
  localparam logic [3:0] REC_LAST_IDX  = 4'd15;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic CFG_ACK_CODE      = 1'b0;
  localparam logic CFG_CONTACTS_FLAG = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_NO_ACK  = 2'd2,
    KIND_BAD_HDR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         contact_id;
    logic [7:0]         contact_type;
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    logic [15:0]        force_sum;
    logic [15:0]        area;
    logic signed [15:0] orientation;
    logic [15:0]        long_axis;
    logic [15:0]        short_axis;
    logic [7:0]         contact_count;
  } result_t;

endpackage

// File: hdl/touch_contact_frame_parser.sv
// Touch contact frame parser: byte-serial frame header check and record unpacking.
// Depends on tcfp_pkg (phase/kind enums, header positions, result struct).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_stall, op, rx_byte          | in (stall out)
//   output  | out_valid, out_stall, kind .. count      | out (stall in)
//   config  | cfg_we, cfg_index, cfg_data              | in, write only
//
// One item per cycle while in_stall is low: each transfer is decoded against the frame
// state in one combinational pass and its result, if any, lands in the output register.
// out_valid rises in the cycle after the input transfer that produced the result.
// in_stall rises only while the output register holds a result and out_stall is high.
// Synchronous active-high reset: parser idle, config registers zero, output empty.
// Record bytes are a 15-byte shift line with no reset; it is always refilled before use.
module touch_contact_frame_parser (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           rx_byte,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcfp_pkg::kind_t      kind,
  output logic [7:0]           contact_id,
  output logic [7:0]           contact_type,
  output logic [15:0]          x_pos,
  output logic [15:0]          y_pos,
  output logic [15:0]          force_sum,
  output logic [15:0]          area,
  output logic signed [15:0]   orientation,
  output logic [15:0]          long_axis,
  output logic [15:0]          short_axis,
  output logic [7:0]           contact_count
);
  import tcfp_pkg::*;

  // configuration registers
  logic [7:0] ack_code;
  logic [7:0] contacts_flag;

  // frame state
  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [LEN_W-1:0] pay_len, pay_len_next;
  logic [7:0]       content, content_next;
  logic [7:0]       num_contacts, num_contacts_next;

  // record bytes, oldest at index 0
  logic [7:0] rec [REC_BYTES];
  logic       rec_shift;

  // result path
  result_t res, res_q;
  logic    res_valid;

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] rec_idx;
  logic [LEN_W-1:0] len_hi_new;

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // position within the current 16-byte record, 15 marks its last byte
  assign rec_idx    = byte_pos[3:0] - REC_START_LSB;
  assign len_hi_new = {rx_byte, pay_len[7:0]};

  // ---------------------------------------------------------------------
  // Per-item decode
  // ---------------------------------------------------------------------
  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    pay_len_next      = pay_len;
    content_next      = content;
    num_contacts_next = num_contacts;
    rec_shift         = 1'b0;
    res_valid         = 1'b0;
    res               = '0;

    if (op == OP_START) begin
      // restart: always wins, even mid-frame, no result
      phase_next        = PH_HEADER;
      byte_pos_next     = '0;
      pay_len_next      = '0;
      content_next      = '0;
      num_contacts_next = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          // stray bytes are dropped
        end
        PH_HEADER: begin
          byte_pos_next = byte_pos + POS_W'(1);
          priority if (byte_pos == POS_ACK) begin
            if (rx_byte != ack_code) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = KIND_NO_ACK;
            end
          end else if (byte_pos == POS_LEN_LO) begin
            pay_len_next = {pay_len[15:8], rx_byte};
          end else if (byte_pos == POS_LEN_HI) begin
            pay_len_next = len_hi_new;
            // a length below the header overhead can never match
            if (len_hi_new < HDR_OVERHEAD) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = KIND_BAD_HDR;
            end
          end else if (byte_pos == POS_FLAG) begin
            content_next = rx_byte;
          end else if (byte_pos == POS_COUNT) begin
            num_contacts_next = rx_byte;
            if (content != contacts_flag ||
                {4'b0, rx_byte, 4'b0} != (pay_len - HDR_OVERHEAD)) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = KIND_BAD_HDR;
            end else begin
              phase_next = PH_BODY;
            end
          end else begin
            // reserved header bytes
          end
        end
        PH_BODY: begin
          byte_pos_next = byte_pos + POS_W'(1);
          if (byte_pos >= ({1'b0, pay_len} + END_OFFSET)) begin
            phase_next        = PH_IDLE;
            res_valid         = 1'b1;
            res.kind          = KIND_DONE;
            res.contact_count = num_contacts;
          end else if (rec_idx != REC_LAST_IDX) begin
            rec_shift = 1'b1;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_RECORD;
            res.contact_id   = rec[0];
            res.contact_type = rec[1];
            res.x_pos        = {rec[3], rec[2]};
            res.y_pos        = {rec[5], rec[4]};
            res.force_sum    = {rec[7], rec[6]};
            res.area         = {rec[9], rec[8]};
            res.orientation  = {rec[11], rec[10]};
            res.long_axis    = {rec[13], rec[12]};
            res.short_axis   = {rx_byte, rec[14]};
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code      <= '0;
      contacts_flag <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACK_CODE:      ack_code      <= cfg_data;
        CFG_CONTACTS_FLAG: contacts_flag <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_pos     <= '0;
      pay_len      <= '0;
      content      <= '0;
      num_contacts <= '0;
    end else if (in_xfer) begin
      phase        <= phase_next;
      byte_pos     <= byte_pos_next;
      pay_len      <= pay_len_next;
      content      <= content_next;
      num_contacts <= num_contacts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && rec_shift) begin
      for (int i = 0; i < REC_BYTES - 1; i++) begin
        rec[i] <= rec[i+1];
      end
      rec[REC_BYTES-1] <= rx_byte;
    end
  end

  // output register: a new result may load in the same cycle the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      res_q <= res;
    end
  end

  assign kind          = res_q.kind;
  assign contact_id    = res_q.contact_id;
  assign contact_type  = res_q.contact_type;
  assign x_pos         = res_q.x_pos;
  assign y_pos         = res_q.y_pos;
  assign force_sum     = res_q.force_sum;
  assign area          = res_q.area;
  assign orientation   = res_q.orientation;
  assign long_axis     = res_q.long_axis;
  assign short_axis    = res_q.short_axis;
  assign contact_count = res_q.contact_count;

`ifndef ASSERT_OFF
  // input is only held back by a full, stalled output register
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a held result");

  // a start transfer opens a fresh header
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op == OP_START) |=> (phase == PH_HEADER && byte_pos == '0))
    else $error("start did not reset the parser");

  // header never runs past the contact count byte
  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (byte_pos <= POS_COUNT))
    else $error("header position out of range");

  // body only entered past the header
  a_body_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (byte_pos >= REC_START))
    else $error("body position inside header");

  // records carry no contact count
  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RECORD) |-> (contact_count == 8'd0))
    else $error("record with nonzero contact count");
`endif

endmodule
